// ===== rtl/gcot_pkg.sv =====
// Shared types and constants of the channel gap and overlap tracker.
package gcot_pkg;

  localparam int unsigned KeyW  = 104;
  localparam int unsigned TimeW = 53;
  localparam int unsigned LatW  = 54;
  localparam int unsigned RateW = 30;
  localparam int unsigned TolW  = 34;
  localparam int unsigned CfgW  = 4;
  localparam int unsigned SlotW = 8;

  localparam logic [CfgW-1:0]  TolReset = 4'd2;
  localparam logic [RateW-1:0] Dividend = 30'd1000000000;
  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    ST_IN_TIME = 2'd0,
    ST_GAP     = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SRCH,
    B_CMP,
    B_CALC1,
    B_CALC2,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] start_us;
    logic [TimeW-1:0] end_us;
    logic [TimeW-1:0] now_us;
    logic [RateW-1:0] period;
    logic [TolW-1:0]  tol;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== rtl/channel_gap_overlap_tracker.sv =====
// Top level of the channel gap, overlap and latency tracker.
// One packet header is taken per transaction. The front end runs the bit-serial
// division of the sample period, the tolerance product and the hand-off, and holds
// its input stalled until the hand-off to the queue is done, so it takes no new
// transaction while busy. The table sequencer then reads and compares each stored
// channel it searches in turn, since the key table has one registered read port.
// The two halves overlap through a two-entry queue.
// The channel table is reset by clearing its fill count only, so no clearing pass runs.
module channel_gap_overlap_tracker import gcot_pkg::*; #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [47:0]            station_code_i,
  input  logic [23:0]            channel_code_i,
  input  logic [15:0]            network_code_i,
  input  logic [15:0]            location_code_i,
  input  logic [TimeW-1:0]       start_time_us_i,
  input  logic [TimeW-1:0]       end_time_us_i,
  input  logic [RateW-1:0]       rate_millihertz_i,
  input  logic [TimeW-1:0]       now_time_us_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [SlotW-1:0]       slot_index_o,
  output logic [TimeW-1:0]       span_from_us_o,
  output logic [TimeW-1:0]       span_to_us_o,
  output logic [TimeW-1:0]       span_length_us_o,
  output logic signed [LatW-1:0] data_latency_us_o,
  output logic signed [LatW-1:0] packet_latency_us_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i
);

  logic [CfgW-1:0] tol_q;
  fifo_status_t    fifo_status;
  logic            push, pop;
  item_t           push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  gcot_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .station_code_i,
    .channel_code_i,
    .network_code_i,
    .location_code_i,
    .start_time_us_i,
    .end_time_us_i,
    .rate_millihertz_i,
    .now_time_us_i,
    .tol_periods_i (tol_q),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .item_o        (push_item)
  );

  gcot_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (fifo_status)
  );

  gcot_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i,
    .rst_ni,
    .fifo_status_i (fifo_status),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .slot_index_o,
    .span_from_us_o,
    .span_to_us_o,
    .span_length_us_o,
    .data_latency_us_o,
    .packet_latency_us_o
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front end took a transaction without going busy");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> slot_index_o == '0 && packet_latency_us_o == '0)
    else $error("table full result carries a slot or a packet latency");

  a_in_time_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_IN_TIME |-> span_length_us_o == '0 && span_from_us_o == '0)
    else $error("in-time result carries a span");

endmodule

// ===== rtl/gcot_front.sv =====
// Front end: takes a packet header, divides out the sample period and forms the tolerance product.
module gcot_front import gcot_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [47:0]      station_code_i,
  input  logic [23:0]      channel_code_i,
  input  logic [15:0]      network_code_i,
  input  logic [15:0]      location_code_i,
  input  logic [TimeW-1:0] start_time_us_i,
  input  logic [TimeW-1:0] end_time_us_i,
  input  logic [RateW-1:0] rate_millihertz_i,
  input  logic [TimeW-1:0] now_time_us_i,
  input  logic [CfgW-1:0]  tol_periods_i,
  input  fifo_status_t     fifo_status_i,
  output logic             push_o,
  output item_t            item_o
);

  front_state_e state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [RateW:0]   rem_q, rem_d;
  logic [RateW-1:0] quo_q, quo_d;
  logic [RateW-1:0] div_q;
  item_t            item_q;
  logic [RateW:0]   rem_sh;
  logic             ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (state_q == F_IDLE && in_valid_i) begin
      item_q.key      <= {station_code_i, channel_code_i, network_code_i, location_code_i};
      item_q.start_us <= start_time_us_i;
      item_q.end_us   <= end_time_us_i;
      item_q.now_us   <= now_time_us_i;
      div_q <= (rate_millihertz_i == '0) ? RateW'(1) : rate_millihertz_i;
    end
    if (state_q == F_MUL) begin
      item_q.period <= quo_q;
      item_q.tol    <= TolW'(tol_periods_i) * TolW'(quo_q);
    end
  end

  assign rem_sh = {rem_q[RateW-1:0], Dividend[cnt_q]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_DIV;
          cnt_d   = 5'(RateW - 1);
          rem_d   = '0;
          quo_d   = '0;
        end
      end
      F_DIV: begin
        rem_d = ge ? rem_sh - {1'b0, div_q} : rem_sh;
        quo_d = {quo_q[RateW-2:0], ge};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!fifo_status_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign in_stall_o = state_q != F_IDLE;
  assign item_o     = item_q;

endmodule

// ===== rtl/gcot_fifo.sv =====
// Two-entry queue between the front end and the table sequencer.
module gcot_fifo import gcot_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  item_t        item_i,
  input  logic         pop_i,
  output item_t        item_o,
  output fifo_status_t status_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_q];
  assign status_o.full  = cnt_q == 2'd2;
  assign status_o.empty = cnt_q == 2'd0;

endmodule

// ===== rtl/gcot_back.sv =====
// Table sequencer: searches the channel table, classifies timing and holds the result.
module gcot_back import gcot_pkg::*; #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fifo_status_t           fifo_status_i,
  input  item_t                  item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [SlotW-1:0]       slot_index_o,
  output logic [TimeW-1:0]       span_from_us_o,
  output logic [TimeW-1:0]       span_to_us_o,
  output logic [TimeW-1:0]       span_length_us_o,
  output logic signed [LatW-1:0] data_latency_us_o,
  output logic signed [LatW-1:0] packet_latency_us_o
);

  localparam int unsigned IW = $clog2(CHANNELS);
  localparam int unsigned CW = $clog2(CHANNELS + 1);

  back_state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             found_q, found_d;
  logic             full_q, full_d;
  item_t            it_q;
  logic [KeyW-1:0]  key_mem [CHANNELS];
  logic [TimeW-1:0] exp_mem [CHANNELS];
  logic [TimeW-1:0] last_mem [CHANNELS];
  logic [KeyW-1:0]  rd_key_q;
  logic [TimeW-1:0] rd_exp_q, rd_last_q;
  logic             gt_q, flag_q;
  logic [TimeW-1:0] d_q, to_ov_q;
  logic [TimeW:0]   cap_q;
  logic [IW-1:0]    slot;
  logic [TimeW-1:0] next_us, len_ov;
  logic             load, wr_en;
  logic             out_valid_q;
  status_e          status_q;

  assign slot    = found_q ? idx_q[IW-1:0] : count_q[IW-1:0];
  assign next_us = cap_q[TimeW] ? TimeMax : cap_q[TimeW-1:0];
  assign len_ov  = (it_q.start_us > to_ov_q) ? it_q.start_us - to_ov_q
                                             : to_ov_q - it_q.start_us;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    found_q <= found_d;
    full_q  <= full_d;
    if (pop_o) begin
      it_q <= item_i;
    end
    if (state_q == B_SRCH) begin
      rd_key_q  <= key_mem[idx_q[IW-1:0]];
      rd_exp_q  <= exp_mem[idx_q[IW-1:0]];
      rd_last_q <= last_mem[idx_q[IW-1:0]];
    end
    if (state_q == B_CALC1) begin
      gt_q  <= it_q.start_us > rd_exp_q;
      d_q   <= (it_q.start_us > rd_exp_q) ? it_q.start_us - rd_exp_q
                                          : rd_exp_q - it_q.start_us;
      cap_q <= {1'b0, it_q.end_us} + (TimeW + 1)'(it_q.period);
    end
    if (state_q == B_CALC2) begin
      flag_q  <= found_q && ({1'b0, d_q} > (TimeW + 1)'(it_q.tol));
      to_ov_q <= ({1'b0, rd_exp_q} > cap_q) ? cap_q[TimeW-1:0] : rd_exp_q;
    end
    if (wr_en) begin
      if (!found_q) begin
        key_mem[slot] <= it_q.key;
      end
      exp_mem[slot]  <= next_us;
      last_mem[slot] <= it_q.now_us;
    end
    if (load) begin
      data_latency_us_o <= LatW'({1'b0, it_q.now_us}) - LatW'({1'b0, it_q.end_us});
      if (full_q) begin
        status_q            <= ST_FULL;
        slot_index_o        <= '0;
        span_from_us_o      <= '0;
        span_to_us_o        <= '0;
        span_length_us_o    <= '0;
        packet_latency_us_o <= '0;
      end else begin
        slot_index_o        <= SlotW'(slot);
        packet_latency_us_o <= found_q ? LatW'({1'b0, it_q.now_us}) - LatW'({1'b0, rd_last_q})
                                       : '0;
        if (!flag_q) begin
          status_q         <= ST_IN_TIME;
          span_from_us_o   <= '0;
          span_to_us_o     <= '0;
          span_length_us_o <= '0;
        end else if (gt_q) begin
          status_q         <= ST_GAP;
          span_from_us_o   <= rd_exp_q;
          span_to_us_o     <= it_q.start_us;
          span_length_us_o <= d_q;
        end else begin
          status_q         <= (it_q.start_us > to_ov_q) ? ST_GAP : ST_OVERLAP;
          span_from_us_o   <= it_q.start_us;
          span_to_us_o     <= to_ov_q;
          span_length_us_o <= len_ov;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    found_d = found_q;
    full_d  = full_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    wr_en   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!fifo_status_i.empty) begin
          pop_o   = 1'b1;
          idx_d   = '0;
          found_d = 1'b0;
          full_d  = 1'b0;
          state_d = B_SRCH;
        end
      end
      B_SRCH: begin
        if (idx_q == count_q) begin
          full_d  = count_q == CW'(CHANNELS);
          state_d = B_CALC1;
        end else begin
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (rd_key_q == it_q.key) begin
          found_d = 1'b1;
          state_d = B_CALC1;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = B_SRCH;
        end
      end
      B_CALC1: begin
        state_d = B_CALC2;
      end
      B_CALC2: begin
        state_d = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          wr_en   = !full_q;
          state_d = B_IDLE;
          if (!full_q && !found_q) begin
            count_d = count_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule
